/* sv/igmf_pkg.sv */
`default_nettype none
package igmf_pkg;

  localparam int GRID_SIZE_DEF = 64;
  localparam int SUM_W         = 48;
  localparam int CNT_W         = 32;
  localparam int ENTRY_W       = SUM_W + CNT_W;
  localparam int COORD_W       = 17;
  localparam int CELL_W        = 6;
  localparam int DATA_W        = 32;

  localparam logic [31:0] SCALE_RESET = 32'h8000_0000;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ACC   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

endpackage
`default_nettype wire

/* sv/igmf_ram.sv */
`default_nettype none
module igmf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* sv/igmf_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module igmf_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [igmf_pkg::DATA_W-1:0]   dividend_i,
  input  wire logic [igmf_pkg::DATA_W-1:0]   divisor_i,
  output logic                               done_o,
  output logic      [igmf_pkg::DATA_W-1:0]   quotient_o
);

  localparam int W  = igmf_pkg::DATA_W;
  localparam int NW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  div_q;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          run_q, run_d, done_q, done_d;
  logic [W:0]    shifted;
  logic [W+1:0]  trial;

  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = {1'b0, shifted} - {2'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = NW'(W);
      run_d = 1'b1;
    end else if (run_q) begin
      // Keep the trial difference when it does not borrow.
      if (!trial[W+1]) begin
        rem_d = trial[W-1:0];
      end else begin
        rem_d = shifted[W-1:0];
      end
      quo_d = {quo_q[W-2:0], ~trial[W+1]};
      cnt_d = cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

/* sv/importance_grid_max_filter.sv */
`default_nettype none
// Importance grid with a 3x3 max filter on read.
//
// Command channel: drive mode_i and the payload with start_i; a beat is taken
// at a rising edge with start_i high and busy_o low. Busy stays high while the
// command works; commands are handled one at a time.
//   clear      : sweeps every cell to zero.
//   accumulate : read-modify-write of one cell entry.
//   read       : visits the 9 neighbour cells one at a time; a cell outside the
//                grid is skipped, an in-grid cell needs a memory read, and a
//                non-empty cell's average then goes through the bit-serial
//                divider, which sets the rate.
// Result channel: result_valid_o pulses for one cycle with filtered_value_o,
// the cycle after the last neighbour is done. The receiver cannot stall.
// Configuration: cfg_we_i writes weight_scale (Q1.31); write it
// only while busy_o is low.
// Reset: runs the clearing sweep (busy high) and sets weight_scale to 1.0.
// Grid state lives in one memory entry per cell holding {sum, count}.
module importance_grid_max_filter #(
  parameter int GRID_SIZE = igmf_pkg::GRID_SIZE_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [31:0]                        cfg_wdata_i,
  input  wire logic [1:0]                         mode_i,
  input  wire logic [igmf_pkg::COORD_W-1:0]       u_i,
  input  wire logic [igmf_pkg::COORD_W-1:0]       v_i,
  input  wire logic [31:0]                        weight_i,
  input  wire logic [igmf_pkg::CELL_W-1:0]        cell_x_i,
  input  wire logic [igmf_pkg::CELL_W-1:0]        cell_y_i,
  output logic                                    result_valid_o,
  output logic      [igmf_pkg::DATA_W-1:0]        filtered_value_o
);

  localparam int CW    = (GRID_SIZE > 2) ? $clog2(GRID_SIZE) : 1;
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = igmf_pkg::COORD_W + CW;
  localparam int SW    = igmf_pkg::SUM_W;
  localparam int NW    = igmf_pkg::CNT_W;
  localparam int EW    = igmf_pkg::ENTRY_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_ACC_Q, S_ACC_WR, S_RD_ADDR, S_RD_DATA, S_RD_DIV
  } state_e;

  state_e state_q, state_d;

  logic [31:0]                    scale_q;
  logic [igmf_pkg::COORD_W-1:0]   u_q, v_q;
  logic [31:0]                    weight_q;
  logic [igmf_pkg::CELL_W-1:0]    cx_q, cy_q;
  logic [63:0]                    prod_q;
  logic [AW-1:0]                  addr_q, addr_d;
  logic [1:0]                     kx_q, kx_d, ky_q, ky_d;
  logic [31:0]                    best_q, best_d;
  logic                           valid_q, valid_d;

  // Quantize a coordinate: scale by GRID_SIZE-1, round half to even, clamp.
  function automatic logic [CW-1:0] quant(input logic [igmf_pkg::COORD_W-1:0] c);
    logic [PW-1:0]   p;
    logic [CW:0]     q;
    logic [15:0]     r;
    logic [CW+1:0]   qr;
    p  = PW'(c) * PW'(GRID_SIZE - 1);
    q  = p[PW-1:16];
    r  = p[15:0];
    qr = {1'b0, q};
    if (r > 16'h8000 || (r == 16'h8000 && q[0])) begin
      qr = qr + (CW+2)'(1);
    end
    if (qr > (CW+2)'(GRID_SIZE - 1)) begin
      qr = (CW+2)'(GRID_SIZE - 1);
    end
    return qr[CW-1:0];
  endfunction

  logic [CW-1:0] qx, qy;
  logic [AW-1:0] acc_addr;
  assign qx       = quant(u_q);
  assign qy       = quant(v_q);
  assign acc_addr = AW'(qy) * AW'(GRID_SIZE) + AW'(qx);

  // Neighbour position as an 11-bit signed value.
  logic signed [10:0] tx, ty;
  logic               in_grid;
  logic [AW-1:0]      nb_addr;
  assign tx      = $signed({5'b0, cx_q}) + $signed({9'b0, kx_q}) - 11'sd1;
  assign ty      = $signed({5'b0, cy_q}) + $signed({9'b0, ky_q}) - 11'sd1;
  assign in_grid = (tx >= 0) && (tx < GRID_SIZE) && (ty >= 0) && (ty < GRID_SIZE);
  assign nb_addr = AW'(ty[9:0]) * AW'(GRID_SIZE) + AW'(tx[9:0]);

  // Entry memory: {sum, count}.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [SW-1:0] rd_sum;
  logic [NW-1:0] rd_cnt;
  assign rd_sum = ram_rdata[EW-1:NW];
  assign rd_cnt = ram_rdata[NW-1:0];

  igmf_ram #(.Width(EW), .Depth(CELLS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Saturating update of the accumulated entry; the scaled weight is 49 bits.
  logic [SW+1:0] sum_ext;
  logic [SW-1:0] new_sum;
  logic [NW-1:0] new_cnt;
  assign sum_ext = {2'b0, rd_sum} + {1'b0, prod_q[63:15]};
  assign new_sum = (|sum_ext[SW+1:SW]) ? {SW{1'b1}} : sum_ext[SW-1:0];
  assign new_cnt = (&rd_cnt) ? rd_cnt : rd_cnt + NW'(1);

  logic        div_start, div_done;
  logic [31:0] div_quo;

  igmf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_sum[SW-1:16]),
    .divisor_i  (rd_cnt),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  logic accept;
  logic last_nb;
  assign accept  = start_i && (state_q == S_IDLE);
  assign last_nb = (kx_q == 2'd2) && (ky_q == 2'd2);

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    kx_d      = kx_q;
    ky_d      = ky_q;
    best_d    = best_q;
    valid_d   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_raddr = nb_addr;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (igmf_pkg::mode_e'(mode_i))
            igmf_pkg::MODE_CLEAR: begin
              addr_d  = '0;
              state_d = S_CLEAR;
            end
            igmf_pkg::MODE_ACC: state_d = S_ACC_Q;
            igmf_pkg::MODE_READ: begin
              kx_d    = 2'd0;
              ky_d    = 2'd0;
              best_d  = '0;
              state_d = S_RD_ADDR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        ram_we = 1'b1;
        addr_d = addr_q + AW'(1);
        if (addr_q == AW'(CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_ACC_Q: begin
        ram_raddr = acc_addr;
        addr_d    = acc_addr;
        state_d   = S_ACC_WR;
      end
      S_ACC_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {new_sum, new_cnt};
        state_d   = S_IDLE;
      end
      S_RD_ADDR: begin
        if (in_grid) begin
          state_d = S_RD_DATA;
        end else if (last_nb) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          kx_d = (kx_q == 2'd2) ? 2'd0 : kx_q + 2'd1;
          ky_d = (kx_q == 2'd2) ? ky_q + 2'd1 : ky_q;
        end
      end
      S_RD_DATA: begin
        if (rd_cnt != '0) begin
          div_start = 1'b1;
          state_d   = S_RD_DIV;
        end else if (last_nb) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          kx_d    = (kx_q == 2'd2) ? 2'd0 : kx_q + 2'd1;
          ky_d    = (kx_q == 2'd2) ? ky_q + 2'd1 : ky_q;
          state_d = S_RD_ADDR;
        end
      end
      S_RD_DIV: begin
        if (div_done) begin
          if (div_quo > best_q) begin
            best_d = div_quo;
          end
          if (last_nb) begin
            valid_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            kx_d    = (kx_q == 2'd2) ? 2'd0 : kx_q + 2'd1;
            ky_d    = (kx_q == 2'd2) ? ky_q + 2'd1 : ky_q;
            state_d = S_RD_ADDR;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
      kx_q    <= '0;
      ky_q    <= '0;
      best_q  <= '0;
      valid_q <= 1'b0;
      scale_q <= igmf_pkg::SCALE_RESET;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      kx_q    <= kx_d;
      ky_q    <= ky_d;
      // Hold the last maximum; the pulse reads it while best_q is stable.
      best_q  <= best_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
    end
  end

  // Payload capture and the weight product; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      u_q      <= u_i;
      v_q      <= v_i;
      weight_q <= weight_i;
      cx_q     <= cell_x_i;
      cy_q     <= cell_y_i;
    end
    if (state_q == S_ACC_Q) begin
      prod_q <= weight_q * scale_q;
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign result_valid_o   = valid_q;
  assign filtered_value_o = best_q;

  // Result strobe is never held high; it always drops right after it rises.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held");

  // An accepted command other than the unused mode keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i != igmf_pkg::MODE_NONE) |=> busy_o)
    else $error("command not taken");

  // Sweep writes only zeros.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (ram_we && ram_wdata == '0))
    else $error("clear sweep wrote data");

  // Divider finishes only while a read waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_RD_DIV))
    else $error("stray divider result");

endmodule
`default_nettype wire

/* verif/tb_importance_grid_max_filter.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_importance_grid_max_filter;
  import igmf_pkg::*;

  localparam int GRID     = GRID_SIZE_DEF;
  localparam int CELLS    = GRID * GRID;
  localparam int LIMIT    = 2_500_000;
  localparam int DRAIN    = 400;
  localparam int QUIET    = 8;
  localparam logic [SUM_W-1:0] SUM_SAT = '1;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // One queued entry: either a command beat or a weight_scale write.
  typedef struct {
    bit                   is_cfg;
    logic [31:0]          scale;
    mode_e                mode;
    logic [COORD_W-1:0]   u;
    logic [COORD_W-1:0]   v;
    logic [31:0]          weight;
    logic [CELL_W-1:0]    cx;
    logic [CELL_W-1:0]    cy;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic [1:0] mode_i = MODE_NONE;
  logic [COORD_W-1:0] u_i = '0;
  logic [COORD_W-1:0] v_i = '0;
  logic [31:0] weight_i = '0;
  logic [CELL_W-1:0] cell_x_i = '0;
  logic [CELL_W-1:0] cell_y_i = '0;
  logic busy_o;
  logic result_valid_o;
  logic [DATA_W-1:0] filtered_value_o;

  importance_grid_max_filter uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_wdata_i,
    .mode_i, .u_i, .v_i, .weight_i, .cell_x_i, .cell_y_i,
    .result_valid_o, .filtered_value_o
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the grid and the scale register.
  logic [SUM_W-1:0] grid_sum [CELLS];
  logic [CNT_W-1:0] grid_hits [CELLS];
  logic [31:0]      shadow_scale = SCALE_RESET;

  beat_t           pending_beats [$];
  logic [31:0]     expected_values [$];
  int              mismatches = 0;
  int              cycles = 0;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Round half to even, then clamp to the last cell.
  function automatic int unsigned to_cell(input logic [COORD_W-1:0] c);
    logic [COORD_W+7:0] p;
    int unsigned q;
    p = (COORD_W+8)'(c * (GRID - 1));
    q = 32'(p >> 16);
    if (p[15:0] > 16'h8000 || (p[15:0] == 16'h8000 && q[0])) q++;
    if (q > GRID - 1) q = GRID - 1;
    return q;
  endfunction

  task automatic clear_grid();
    for (int i = 0; i < CELLS; i++) begin
      grid_sum[i] = '0;
      grid_hits[i] = '0;
    end
  endtask

  task automatic add_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                            input logic [31:0] w);
    int unsigned id;
    logic [63:0] add;
    id = to_cell(v) * GRID + to_cell(u);
    add = (64'(w) * 64'(shadow_scale)) >> 15;
    if (add > 64'(SUM_SAT - grid_sum[id])) grid_sum[id] = SUM_SAT;
    else grid_sum[id] = grid_sum[id] + add[SUM_W-1:0];
    if (grid_hits[id] != CNT_SAT) grid_hits[id]++;
  endtask

  function automatic logic [31:0] neighborhood_max(input int cx, input int cy);
    logic [31:0] best;
    logic [63:0] avg;
    int tx, ty, id;
    best = '0;
    for (int ky = -1; ky <= 1; ky++)
      for (int kx = -1; kx <= 1; kx++) begin
        tx = cx + kx;
        ty = cy + ky;
        if (tx >= 0 && tx < GRID && ty >= 0 && ty < GRID) begin
          id = ty * GRID + tx;
          if (grid_hits[id] != 0) begin
            avg = 64'(grid_sum[id]) / (64'(grid_hits[id]) << 16);
            if (avg[31:0] > best) best = avg[31:0];
          end
        end
      end
    return best;
  endfunction

  // Driver: bursts of beats with random gaps; scale writes only when idle.
  int  burst_left = 0;
  int  gap_left = 0;
  int  quiet_cycles = 0;
  logic stim_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t b;
    logic nxt_start, nxt_we;
    if (!rst_ni) begin
      start_i <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      nxt_start = start_i;
      nxt_we = 1'b0;
      // Predict on the accepting edge, using the fields still on the ports.
      if (start_i && !busy_o) begin
        case (mode_e'(mode_i))
          MODE_CLEAR: clear_grid();
          MODE_ACC:   add_sample(u_i, v_i, weight_i);
          MODE_READ:  expected_values.push_back(neighborhood_max(cell_x_i, cell_y_i));
          default: ;
        endcase
        nxt_start = 1'b0;
      end
      quiet_cycles <= (!busy_o && !start_i) ? quiet_cycles + 1 : 0;
      if (!(start_i && busy_o)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_beats.size() > 0) begin
          b = pending_beats[0];
          if (b.is_cfg) begin
            // Hold until the block has drained and sat idle for a while.
            if (expected_values.size() == 0 && !busy_o && !start_i &&
                quiet_cycles >= QUIET) begin
              nxt_we = 1'b1;
              cfg_wdata_i <= b.scale;
              shadow_scale = b.scale;
              void'(pending_beats.pop_front());
            end
          end else begin
            nxt_start = 1'b1;
            mode_i <= b.mode;
            u_i <= b.u;
            v_i <= b.v;
            weight_i <= b.weight;
            cell_x_i <= b.cx;
            cell_y_i <= b.cy;
            void'(pending_beats.pop_front());
            if (burst_left > 1) begin
              burst_left <= burst_left - 1;
            end else begin
              burst_left <= $urandom_range(1, 24);
              case ($urandom_range(0, 9))
                0, 1, 2: gap_left <= 0;
                9:       gap_left <= $urandom_range(20, 60);
                default: gap_left <= $urandom_range(1, 6);
              endcase
            end
          end
        end else if (!start_i || !busy_o) begin
          stim_done <= 1'b1;
        end
      end
      start_i <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && result_valid_o) begin
      if (expected_values.size() == 0) begin
        report($sformatf("unexpected result %h", filtered_value_o));
      end else begin
        want = expected_values.pop_front();
        if (filtered_value_o !== want)
          report($sformatf("filtered_value %h, want %h", filtered_value_o, want));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("** importance_grid_max_filter: FAILED **");
      $finish;
    end
  end

  function automatic beat_t cmd(input mode_e m, input int u, input int v, input logic [31:0] w,
                                input int cx, input int cy);
    beat_t b;
    b.is_cfg = 1'b0;
    b.scale = '0;
    b.mode = m;
    b.u = COORD_W'(u);
    b.v = COORD_W'(v);
    b.weight = w;
    b.cx = CELL_W'(cx);
    b.cy = CELL_W'(cy);
    return b;
  endfunction

  function automatic beat_t scale_write(input logic [31:0] s);
    beat_t b;
    b = cmd(MODE_NONE, 0, 0, 0, 0, 0);
    b.is_cfg = 1'b1;
    b.scale = s;
    return b;
  endfunction

  // Hot zones keep reads landing next to filled cells.
  function automatic int hot_cell();
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, 4);
      1:       return $urandom_range(GRID - 5, GRID - 1);
      default: return $urandom_range(GRID / 2 - 3, GRID / 2 + 3);
    endcase
  endfunction

  function automatic int rand_coord();
    int c;
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, (1 << COORD_W) - 1);
      1, 2:    return $urandom_range(0, 65536);
      default: begin
        c = (hot_cell() * 65536) / (GRID - 1) + $urandom_range(0, 1200) - 600;
        return (c < 0) ? 0 : c;
      end
    endcase
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 9))
      0:       return 32'hFFFF_FFFF;
      1:       return '0;
      2, 3:    return $urandom_range(0, 32'h0003_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic beat_t rand_beat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 1)  return cmd(MODE_CLEAR, $urandom_range(0, 131071), $urandom_range(0, 131071),
                           $urandom(), $urandom_range(0, 63), $urandom_range(0, 63));
    if (r < 5)  return cmd(MODE_NONE, $urandom_range(0, 131071), $urandom_range(0, 131071),
                           $urandom(), $urandom_range(0, 63), $urandom_range(0, 63));
    if (r < 58) return cmd(MODE_ACC, rand_coord(), rand_coord(), rand_weight(),
                           $urandom_range(0, 63), $urandom_range(0, 63));
    if (r < 92) return cmd(MODE_READ, $urandom_range(0, 131071), $urandom_range(0, 131071),
                           $urandom(), hot_cell(), hot_cell());
    return cmd(MODE_READ, rand_coord(), rand_coord(), $urandom(),
               $urandom_range(0, 63), $urandom_range(0, 63));
  endfunction

  initial begin
    logic [31:0] phase_scale [5];
    phase_scale = '{32'hFFFF_FFFF, $urandom(), 32'h0000_0001, 32'h0000_0000, 32'h8000_0000};
    clear_grid();

    // Directed: empty read, saturation, clamping, half-even ties, corners, unused mode.
    pending_beats.push_back(cmd(MODE_READ, 0, 0, 0, 0, 0));
    pending_beats.push_back(cmd(MODE_ACC, 0, 0, 32'hFFFF_FFFF, 0, 0));
    pending_beats.push_back(cmd(MODE_ACC, 0, 0, 32'hFFFF_FFFF, 0, 0));
    pending_beats.push_back(cmd(MODE_READ, 0, 0, 0, 0, 0));
    pending_beats.push_back(cmd(MODE_READ, 0, 0, 0, 1, 1));
    pending_beats.push_back(cmd(MODE_ACC, 65536, 131071, 32'h0001_0000, 0, 0));
    pending_beats.push_back(cmd(MODE_READ, 0, 0, 0, 63, 63));
    pending_beats.push_back(cmd(MODE_ACC, 32768, 98304, 32'd12345, 0, 0));
    pending_beats.push_back(cmd(MODE_ACC, 32767, 65536, 32'h0005_0000, 0, 0));
    pending_beats.push_back(cmd(MODE_READ, 0, 0, 0, 32, 63));
    pending_beats.push_back(cmd(MODE_READ, 0, 0, 0, 31, 62));
    pending_beats.push_back(cmd(MODE_NONE, 131071, 131071, 32'hFFFF_FFFF, 63, 63));
    pending_beats.push_back(cmd(MODE_READ, 131071, 131071, 32'hFFFF_FFFF, 62, 0));
    pending_beats.push_back(cmd(MODE_CLEAR, 0, 0, 0, 0, 0));
    pending_beats.push_back(cmd(MODE_READ, 0, 0, 0, 0, 0));
    pending_beats.push_back(cmd(MODE_READ, 0, 0, 0, 63, 63));
    pending_beats.push_back(scale_write(32'hFFFF_FFFF));
    pending_beats.push_back(cmd(MODE_ACC, 1040, 0, 32'hFFFF_FFFF, 0, 0));
    pending_beats.push_back(cmd(MODE_ACC, 0, 1040, 32'h0000_0001, 0, 0));
    pending_beats.push_back(cmd(MODE_READ, 0, 0, 0, 0, 0));
    pending_beats.push_back(cmd(MODE_READ, 0, 0, 0, 1, 0));

    // Random phases, each under a different scale.
    for (int p = 0; p < 5; p++) begin
      pending_beats.push_back(scale_write(phase_scale[p]));
      for (int i = 0; i < 246; i++) pending_beats.push_back(rand_beat());
    end

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (stim_done && expected_values.size() == 0);
    repeat (DRAIN) @(posedge clk_i);
    if (expected_values.size() != 0) report("results still outstanding at end of run");
    if (mismatches == 0) begin
      $display("** importance_grid_max_filter: PASSED **");
    end else begin
      $display("** importance_grid_max_filter: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
